FILE: hw/rtl/coalescing_input_event_queue_core_assert.svh
// Assertion macros used by the event queue core RTL.
`ifndef COALESCING_INPUT_EVENT_QUEUE_CORE_ASSERT_SVH
`define COALESCING_INPUT_EVENT_QUEUE_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define CIEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define CIEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/cieq_pkg.sv
`default_nettype none

package cieq_pkg;

    // Operation codes carried by the op input.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Configuration register indexes.
    localparam logic REG_SURFACE_WIDTH  = 1'b0;
    localparam logic REG_SURFACE_HEIGHT = 1'b1;

    localparam int SIZE_W = 13;

    // Event kinds.
    typedef enum logic [1:0] {
        KIND_MOTION   = 2'd0,
        KIND_BUTTON   = 2'd1,
        KIND_KEYBOARD = 2'd2,
        KIND_INVALID  = 2'd3
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // One queued event as it sits in the ring storage.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [7:0]         button;
        logic [31:0]        serial;
    } entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cieq_ram.sv
`default_nettype none

module cieq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/coalescing_input_event_queue_core.sv
`default_nettype none
// Every accepted command gives its result in the next cycle, strobed by done.
// Throughput: one command per cycle; busy is always low, since head, count and the
// ring write port all settle in the cycle of the transfer.
// Dequeued payload comes from the ring RAM read port, registered in that same cycle.
// Reset clears head, count and the size registers; the ring itself is not cleared.

`include "coalescing_input_event_queue_core_assert.svh"

module coalescing_input_event_queue_core
    import cieq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Configuration write port.
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [SIZE_W-1:0]  cfg_data,
    // Command side.
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               op,
    input  wire logic [1:0]         event_kind,
    input  wire logic signed [15:0] pos_x,
    input  wire logic signed [15:0] pos_y,
    input  wire logic [7:0]         button_code,
    input  wire logic [31:0]        event_serial,
    // Result side.
    output logic                    done,
    output logic [1:0]              status,
    output logic [1:0]              out_kind,
    output logic signed [15:0]      out_x,
    output logic signed [15:0]      out_y,
    output logic [7:0]              out_button,
    output logic [31:0]             out_serial
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int ENTRY_W = $bits(entry_t);

    logic [SIZE_W-1:0] surface_width_reg;
    logic [SIZE_W-1:0] surface_height_reg;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             last_motion_reg, last_motion_next;
    logic             motion_flag_reg [QUEUE_DEPTH];

    logic    done_reg;
    status_t status_reg, status_next;
    logic    pop_ok_reg;

    logic             accept;
    logic             is_motion;
    logic             event_ok;
    logic             x_ok;
    logic             y_ok;
    logic             coalesce;
    logic             full;
    logic             drop_oldest;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             rd_en;
    logic [SUM_W-1:0] tail_sum;
    logic [SUM_W-1:0] last_sum;
    logic [IDX_W-1:0] tail_idx;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] head_inc;
    entry_t           wr_entry;
    entry_t           rd_entry;
    logic [ENTRY_W-1:0] rd_data;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration registers; an unknown index cannot occur with a one-bit index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            surface_width_reg  <= '0;
            surface_height_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SURFACE_WIDTH:  surface_width_reg  <= cfg_data;
                REG_SURFACE_HEIGHT: surface_height_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Ring positions: tail is the next free slot, last the newest entry.
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign last_sum = tail_sum - SUM_W'(1);
    assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
    assign last_idx = (last_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      IDX_W'(last_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(last_sum);
    assign head_inc = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);

    // Event checks; pointer coordinates must be nonnegative and inside the surface.
    assign is_motion = (event_kind == KIND_MOTION);
    assign x_ok = !pos_x[15] && ({2'b00, pos_x[14:0]} < {4'b0000, surface_width_reg});
    assign y_ok = !pos_y[15] && ({2'b00, pos_y[14:0]} < {4'b0000, surface_height_reg});

    always_comb
    begin
        event_ok = (event_serial != 32'd0) && (event_kind != KIND_INVALID);
        if (event_kind != KIND_KEYBOARD && !(x_ok && y_ok))
        begin
            event_ok = 1'b0;
        end
        if (event_kind == KIND_BUTTON && button_code == 8'd0)
        begin
            event_ok = 1'b0;
        end
    end

    assign coalesce    = is_motion && (count_reg != '0) && last_motion_reg;
    assign full        = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign drop_oldest = full && motion_flag_reg[head_reg];

    // Command decode and state update.
    always_comb
    begin
        head_next        = head_reg;
        count_next       = count_reg;
        last_motion_next = last_motion_reg;
        status_next      = ST_OK;
        wr_en            = 1'b0;
        wr_idx           = tail_idx;
        rd_en            = 1'b0;
        if (accept)
        begin
            if (op == OP_ENQUEUE)
            begin
                if (!event_ok)
                begin
                    status_next = ST_INVALID;
                end
                else if (coalesce)
                begin
                    wr_en  = 1'b1;
                    wr_idx = last_idx;
                end
                else if (drop_oldest)
                begin
                    // Oldest motion entry makes room; its slot becomes the newest entry.
                    wr_en            = 1'b1;
                    wr_idx           = head_reg;
                    head_next        = head_inc;
                    last_motion_next = is_motion;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en            = 1'b1;
                    count_next       = count_reg + CNT_W'(1);
                    last_motion_next = is_motion;
                end
            end
            else
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en      = 1'b1;
                    head_next  = head_inc;
                    count_next = count_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            count_reg       <= '0;
            last_motion_reg <= 1'b0;
            done_reg        <= 1'b0;
            status_reg      <= ST_OK;
            pop_ok_reg      <= 1'b0;
        end
        else
        begin
            head_reg        <= head_next;
            count_reg       <= count_next;
            last_motion_reg <= last_motion_next;
            done_reg        <= accept;
            status_reg      <= status_next;
            pop_ok_reg      <= rd_en;
        end
    end

    // Per-slot motion marks, read at the head for the drop decision.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            motion_flag_reg[wr_idx] <= is_motion;
        end
    end

    // Ring payload storage.
    assign wr_entry.kind   = event_kind;
    assign wr_entry.x      = pos_x;
    assign wr_entry.y      = pos_y;
    assign wr_entry.button = button_code;
    assign wr_entry.serial = event_serial;

    cieq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    // Result fields; payload is zero unless a dequeue returned an entry.
    assign rd_entry   = entry_t'(rd_data);
    assign done       = done_reg;
    assign status     = status_reg;
    assign out_kind   = pop_ok_reg ? rd_entry.kind   : 2'd0;
    assign out_x      = pop_ok_reg ? rd_entry.x      : 16'sd0;
    assign out_y      = pop_ok_reg ? rd_entry.y      : 16'sd0;
    assign out_button = pop_ok_reg ? rd_entry.button : 8'd0;
    assign out_serial = pop_ok_reg ? rd_entry.serial : 32'd0;

    // Assertions.
    `CIEQ_ASSERT_NEXT(a_done_follows_transfer, accept, done, "result strobe missing after transfer")
    `CIEQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
    `CIEQ_ASSERT_NOW(a_full_status, done && status_reg == ST_FULL, full, "full status with free slots")
    `CIEQ_ASSERT_NOW(a_empty_status, done && status_reg == ST_EMPTY, count_reg == '0, "empty status with entries")
    `CIEQ_ASSERT_NOW(a_pop_payload, pop_ok_reg, done && status_reg == ST_OK, "payload without a good dequeue")

endmodule

`default_nettype wire
